### sv/text_console_writer_macros.svh
// Assertion macros used by the checker file of the text console writer.
// Depends on nothing; include it by its bare file name.
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define TCW_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define TCW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds through reset.
`define TCW_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/tcw_pkg.sv
// Shared types and constants of the text console writer.
// Used by the controller, the datapath, the top level and the checker.
package tcw_pkg;

  localparam int ADDR_W = 12;
  localparam int COL_W = 7;
  localparam int ROW_W = 6;
  localparam int CELL_W = 16;
  localparam int CFG_W = 7;
  localparam int CFG_IDX_W = 3;

  localparam logic [COL_W-1:0] MAX_COLS = 7'd80;
  localparam logic [ROW_W-1:0] MAX_ROWS = 6'd50;

  localparam logic [COL_W-1:0] RESET_COLUMNS = 7'd80;
  localparam logic [ROW_W-1:0] RESET_ROWS = 6'd25;
  localparam logic [3:0] RESET_FG = 4'hF;
  localparam logic [3:0] RESET_BG = 4'h0;

  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FG = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BG = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHOWN = 3'd4;

  localparam logic [7:0] CH_BEL = 8'h07;
  localparam logic [7:0] CH_BS = 8'h08;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_VT = 8'h0B;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [1:0] {
    KIND_PUT,
    KIND_CLEAR,
    KIND_SET,
    KIND_READ
  } kind_t;

  typedef enum logic [1:0] {
    SW_WIPE,
    SW_COPY,
    SW_LAST,
    SW_FILL
  } sweep_t;

  typedef enum logic [1:0] {
    ACT_DONE,
    ACT_SCROLL,
    ACT_FILL
  } act_t;

  typedef enum logic [2:0] {
    S_WIPE,
    S_IDLE,
    S_EXEC,
    S_COPY,
    S_LAST,
    S_DRAIN,
    S_FILL,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic   latch;
    logic   exec;
    logic   step;
    sweep_t mode;
    logic   ptr_load;
    sweep_t load_mode;
    logic   out_load;
  } cmd_t;

  typedef struct packed {
    act_t act;
    logic single_row;
    logic ptr_end;
  } stat_t;

endpackage

### sv/tcw_ctrl.sv
// Controller state machine of the text console writer.
// Depends on tcw_pkg; drives the datapath through tcw_pkg::cmd_t.
module tcw_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  tcw_pkg::stat_t stat,
  output tcw_pkg::cmd_t  cmd
);

  tcw_pkg::state_t state;
  tcw_pkg::state_t state_next;
  logic            out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcw_pkg::S_WIPE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tcw_pkg::S_WIPE: begin
        if (stat.ptr_end) state_next = tcw_pkg::S_IDLE;
      end
      tcw_pkg::S_IDLE: begin
        if (in_valid) state_next = tcw_pkg::S_EXEC;
      end
      tcw_pkg::S_EXEC: begin
        unique case (stat.act)
          tcw_pkg::ACT_SCROLL:
            state_next = stat.single_row ? tcw_pkg::S_LAST : tcw_pkg::S_COPY;
          tcw_pkg::ACT_FILL: state_next = tcw_pkg::S_FILL;
          default: state_next = tcw_pkg::S_FINISH;
        endcase
      end
      tcw_pkg::S_COPY: begin
        if (stat.ptr_end) state_next = tcw_pkg::S_LAST;
      end
      tcw_pkg::S_LAST: begin
        if (stat.ptr_end) state_next = tcw_pkg::S_DRAIN;
      end
      tcw_pkg::S_DRAIN: state_next = tcw_pkg::S_FINISH;
      tcw_pkg::S_FILL: begin
        if (stat.ptr_end) state_next = tcw_pkg::S_FINISH;
      end
      tcw_pkg::S_FINISH: begin
        if (out_free) state_next = in_valid ? tcw_pkg::S_EXEC : tcw_pkg::S_IDLE;
      end
      default: state_next = tcw_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      tcw_pkg::S_WIPE: begin
        cmd.step = 1'b1;
        cmd.mode = tcw_pkg::SW_WIPE;
      end
      tcw_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.latch = in_valid;
      end
      tcw_pkg::S_EXEC: begin
        cmd.exec = 1'b1;
        unique case (stat.act)
          tcw_pkg::ACT_SCROLL: begin
            cmd.ptr_load = 1'b1;
            cmd.load_mode = stat.single_row ? tcw_pkg::SW_LAST : tcw_pkg::SW_COPY;
          end
          tcw_pkg::ACT_FILL: begin
            cmd.ptr_load = 1'b1;
            cmd.load_mode = tcw_pkg::SW_FILL;
          end
          default: ;
        endcase
      end
      tcw_pkg::S_COPY: begin
        cmd.step = 1'b1;
        cmd.mode = tcw_pkg::SW_COPY;
        if (stat.ptr_end) begin
          cmd.ptr_load = 1'b1;
          cmd.load_mode = tcw_pkg::SW_LAST;
        end
      end
      tcw_pkg::S_LAST: begin
        cmd.step = 1'b1;
        cmd.mode = tcw_pkg::SW_LAST;
      end
      tcw_pkg::S_DRAIN: ;
      tcw_pkg::S_FILL: begin
        cmd.step = 1'b1;
        cmd.mode = tcw_pkg::SW_FILL;
      end
      tcw_pkg::S_FINISH: begin
        cmd.out_load = out_free;
        in_ready = out_free;
        cmd.latch = out_free && in_valid;
      end
      default: ;
    endcase
  end

endmodule

### sv/tcw_datapath.sv
// Datapath of the text console writer: configuration, cursor, screen memory,
// sweep pointer and result register. Depends on tcw_pkg; driven by tcw_ctrl.
module tcw_datapath #(
  parameter int SCREEN_CELLS = 4096,
  parameter int TAB_STOP = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tcw_pkg::CFG_W-1:0]         cfg_data,
  input  logic [1:0]                        kind,
  input  logic [7:0]                        char_code,
  input  logic signed [7:0]                 new_column,
  input  logic signed [6:0]                 new_row,
  input  logic [tcw_pkg::ADDR_W-1:0]        cell_index,
  input  tcw_pkg::cmd_t                     cmd,
  output tcw_pkg::stat_t                    stat,
  output logic [tcw_pkg::COL_W-1:0]         cursor_column,
  output logic [tcw_pkg::ROW_W-1:0]         cursor_row,
  output logic [tcw_pkg::ADDR_W-1:0]        hw_cursor_position,
  output logic [tcw_pkg::CELL_W-1:0]        cell_value
);

  localparam int FULL_DEPTH = 1 << tcw_pkg::ADDR_W;
  localparam int DEPTH = (SCREEN_CELLS < FULL_DEPTH) ? SCREEN_CELLS : FULL_DEPTH;
  localparam int MW = $clog2(DEPTH);
  localparam logic [14:0] CELL_LIMIT = 15'(SCREEN_CELLS);
  localparam logic [tcw_pkg::ADDR_W-1:0] WIPE_END = tcw_pkg::ADDR_W'(DEPTH - 1);

  // Configuration.
  logic [6:0] columns;
  logic [5:0] rows;
  logic [3:0] fg_color;
  logic [3:0] bg_color;
  logic       cursor_shown;
  logic [6:0] nc;
  logic [5:0] nr;
  logic [12:0] area_prod;
  logic [12:0] area_m_nc_prod;
  logic [11:0] area;
  logic [11:0] area_m_nc;

  // Item and cursor.
  tcw_pkg::kind_t kind_r;
  logic [7:0]  char_r;
  logic [7:0]  ncol_r;
  logic [6:0]  nrow_r;
  logic [11:0] idx_r;
  logic [6:0]  col;
  logic [5:0]  row;
  logic [6:0]  col_sat;
  logic [5:0]  row_sat;
  logic [6:0]  col_new;
  logic [5:0]  row_new;
  logic [6:0]  col_dec;
  logic [6:0]  col_inc;
  logic [6:0]  addr_col;
  logic [12:0] row_nc;
  logic [11:0] exec_addr;
  logic [7:0]  tab_tbl [128];
  logic [7:0]  tab_next;
  logic        line_feed;
  logic        wr_exec;
  logic [15:0] wr_exec_data;
  tcw_pkg::act_t act;

  // Sweep and memory.
  logic [11:0] ptr;
  logic [11:0] ptr_start;
  logic        sweep_read;
  logic        rd_req;
  logic [11:0] rd_addr;
  logic        rd_inr;
  logic        rd_inr_d;
  logic [15:0] rdata;
  logic [15:0] src;
  logic        pipe_vld;
  logic [11:0] pipe_dst;
  logic        pipe_last;
  logic        mem_we;
  logic [11:0] mem_wa;
  logic [15:0] mem_wd;
  logic        mem_wr_ok;
  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      columns <= tcw_pkg::RESET_COLUMNS;
      rows <= tcw_pkg::RESET_ROWS;
      fg_color <= tcw_pkg::RESET_FG;
      bg_color <= tcw_pkg::RESET_BG;
      cursor_shown <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        tcw_pkg::REG_COLUMNS: columns <= cfg_data;
        tcw_pkg::REG_ROWS: rows <= cfg_data[5:0];
        tcw_pkg::REG_FG: fg_color <= cfg_data[3:0];
        tcw_pkg::REG_BG: bg_color <= cfg_data[3:0];
        tcw_pkg::REG_SHOWN: cursor_shown <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (columns == 7'd0) nc = 7'd1;
    else if (columns > tcw_pkg::MAX_COLS) nc = tcw_pkg::MAX_COLS;
    else nc = columns;
    if (rows == 6'd0) nr = 6'd1;
    else if (rows > tcw_pkg::MAX_ROWS) nr = tcw_pkg::MAX_ROWS;
    else nr = rows;
  end

  assign area_prod = 13'(nc) * 13'(nr);
  assign area_m_nc_prod = 13'(nc) * 13'(nr - 6'd1);

  always_ff @(posedge clk) begin
    area <= area_prod[11:0];
    area_m_nc <= area_m_nc_prod[11:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_r <= tcw_pkg::kind_t'(kind);
      char_r <= char_code;
      ncol_r <= new_column;
      nrow_r <= new_row;
      idx_r <= cell_index;
    end
  end

  for (genvar g = 0; g < 128; g++) begin : g_tab
    assign tab_tbl[g] = 8'(((g + TAB_STOP) / TAB_STOP) * TAB_STOP);
  end

  assign col_sat = (col >= nc) ? nc - 7'd1 : col;
  assign row_sat = (row >= nr) ? nr - 6'd1 : row;
  assign col_dec = (col != 7'd0) ? col - 7'd1 : col;
  assign col_inc = col + 7'd1;
  assign tab_next = tab_tbl[col];
  assign row_nc = 13'(row) * 13'(nc);
  assign exec_addr = row_nc[11:0] + {5'd0, addr_col};

  always_comb begin
    col_new = col;
    row_new = row;
    addr_col = col;
    line_feed = 1'b0;
    wr_exec = 1'b0;
    wr_exec_data = {bg_color, fg_color, char_r};
    act = tcw_pkg::ACT_DONE;
    unique case (kind_r)
      tcw_pkg::KIND_PUT: begin
        unique case (char_r)
          tcw_pkg::CH_CR, tcw_pkg::CH_VT, tcw_pkg::CH_BEL: ;
          tcw_pkg::CH_LF: line_feed = 1'b1;
          tcw_pkg::CH_TAB: begin
            if ({1'b0, nc} <= tab_next) line_feed = 1'b1;
            else col_new = tab_next[6:0];
          end
          tcw_pkg::CH_BS: begin
            col_new = col_dec;
            addr_col = col_dec;
            wr_exec = 1'b1;
            wr_exec_data = {bg_color, fg_color, tcw_pkg::CH_SPACE};
          end
          default: begin
            wr_exec = 1'b1;
            if (col_inc >= nc) line_feed = 1'b1;
            else col_new = col_inc;
          end
        endcase
      end
      tcw_pkg::KIND_CLEAR: act = tcw_pkg::ACT_FILL;
      tcw_pkg::KIND_SET: begin
        if (!ncol_r[7]) col_new = (ncol_r[6:0] >= nc) ? nc - 7'd1 : ncol_r[6:0];
        if (!nrow_r[6]) row_new = (nrow_r[5:0] >= nr) ? nr - 6'd1 : nrow_r[5:0];
      end
      tcw_pkg::KIND_READ: ;
      default: ;
    endcase
    if (line_feed) begin
      col_new = 7'd0;
      if ({1'b0, row} + 7'd1 >= {1'b0, nr}) begin
        row_new = nr - 6'd1;
        act = tcw_pkg::ACT_SCROLL;
      end else begin
        row_new = row + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (cmd.latch) begin
      col <= col_sat;
      row <= row_sat;
    end else if (cmd.exec) begin
      col <= col_new;
      row <= row_new;
    end
  end

  always_comb begin
    unique case (cmd.load_mode)
      tcw_pkg::SW_COPY: ptr_start = {5'd0, nc};
      tcw_pkg::SW_LAST: ptr_start = area_m_nc;
      default: ptr_start = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else if (cmd.ptr_load) begin
      ptr <= ptr_start;
    end else if (cmd.step) begin
      ptr <= ptr + 12'd1;
    end
  end

  assign stat.act = act;
  assign stat.single_row = (nr == 6'd1);
  assign stat.ptr_end = (cmd.mode == tcw_pkg::SW_WIPE) ? (ptr == WIPE_END)
                                                       : (ptr == area - 12'd1);

  assign sweep_read = cmd.step &&
                      (cmd.mode == tcw_pkg::SW_COPY || cmd.mode == tcw_pkg::SW_LAST);

  always_comb begin
    rd_req = 1'b0;
    rd_addr = ptr;
    if (cmd.exec && kind_r == tcw_pkg::KIND_READ) begin
      rd_req = 1'b1;
      rd_addr = idx_r;
    end else if (sweep_read) begin
      rd_req = 1'b1;
    end
  end

  assign rd_inr = {3'd0, rd_addr} < CELL_LIMIT;
  assign src = rd_inr_d ? rdata : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_vld <= 1'b0;
    end else begin
      pipe_vld <= sweep_read;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_req) rd_inr_d <= rd_inr;
    pipe_dst <= (cmd.mode == tcw_pkg::SW_COPY) ? ptr - {5'd0, nc} : ptr;
    pipe_last <= (cmd.mode == tcw_pkg::SW_LAST);
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = ptr;
    mem_wd = '0;
    priority if (cmd.exec && wr_exec) begin
      mem_we = 1'b1;
      mem_wa = exec_addr;
      mem_wd = wr_exec_data;
    end else if (cmd.step && cmd.mode == tcw_pkg::SW_WIPE) begin
      mem_we = 1'b1;
    end else if (cmd.step && cmd.mode == tcw_pkg::SW_FILL) begin
      mem_we = 1'b1;
      mem_wd = {bg_color, fg_color, tcw_pkg::CH_SPACE};
    end else if (pipe_vld) begin
      mem_we = 1'b1;
      mem_wa = pipe_dst;
      mem_wd = pipe_last ? {src[15:8], tcw_pkg::CH_SPACE} : src;
    end else begin
      mem_we = 1'b0;
    end
  end

  assign mem_wr_ok = mem_we && ({3'd0, mem_wa} < CELL_LIMIT);

  always_ff @(posedge clk) begin
    if (mem_wr_ok) mem[mem_wa[MW-1:0]] <= mem_wd;
    if (rd_req && rd_inr) rdata <= mem[rd_addr[MW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      cursor_column <= col;
      cursor_row <= row;
      hw_cursor_position <= cursor_shown ? row_nc[11:0] + {5'd0, col} : area + {5'd0, nc};
      cell_value <= (kind_r == tcw_pkg::KIND_READ) ? src : '0;
    end
  end

endmodule

### sv/text_console_writer.sv
// Top level of the text console writer: controller plus datapath.
// Depends on tcw_pkg, tcw_ctrl and tcw_datapath.
//
// Channel  Direction  Handshake                Payload
// in       input      in_valid / in_ready      kind, char_code, new_column, new_row, cell_index
// out      output     out_valid / out_ready    cursor_column, cursor_row, hw_cursor_position,
//                                              cell_value
// cfg      input      cfg_write                cfg_index, cfg_data
//
// A plain character, cursor move or cell read is latched, executed and then loaded as a result.
// A line feed at the bottom row adds a scroll sweep that moves the lower rows up and blanks the
// last row, and a clear screen adds a fill sweep; both use the single screen memory port pair.
// After reset a wipe pass clears min(SCREEN_CELLS, 4096) cells before in_ready rises.
// One item is worked at a time; the next is taken while a finished result waits in the
// output register, and a stalled output holds the block only when a second result is ready.
module text_console_writer #(
  parameter int SCREEN_CELLS = 4096,
  parameter int TAB_STOP = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tcw_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    kind,
  input  logic [7:0]                    char_code,
  input  logic signed [7:0]             new_column,
  input  logic signed [6:0]             new_row,
  input  logic [tcw_pkg::ADDR_W-1:0]    cell_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tcw_pkg::COL_W-1:0]     cursor_column,
  output logic [tcw_pkg::ROW_W-1:0]     cursor_row,
  output logic [tcw_pkg::ADDR_W-1:0]    hw_cursor_position,
  output logic [tcw_pkg::CELL_W-1:0]    cell_value
);

  tcw_pkg::cmd_t  cmd;
  tcw_pkg::stat_t stat;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tcw_datapath #(
    .SCREEN_CELLS (SCREEN_CELLS),
    .TAB_STOP     (TAB_STOP)
  ) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cfg_write          (cfg_write),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .kind               (kind),
    .char_code          (char_code),
    .new_column         (new_column),
    .new_row            (new_row),
    .cell_index         (cell_index),
    .cmd                (cmd),
    .stat               (stat),
    .cursor_column      (cursor_column),
    .cursor_row         (cursor_row),
    .hw_cursor_position (hw_cursor_position),
    .cell_value         (cell_value)
  );

endmodule

### sv/tcw_checker.sv
// Port-level checker of the text console writer and its bind to the top level.
// Depends on tcw_pkg and text_console_writer_macros.svh.
`include "text_console_writer_macros.svh"

module tcw_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [tcw_pkg::COL_W-1:0]     cursor_column,
  input logic [tcw_pkg::ROW_W-1:0]     cursor_row,
  input logic [tcw_pkg::ADDR_W-1:0]    hw_cursor_position,
  input logic [tcw_pkg::CELL_W-1:0]    cell_value
);

  `TCW_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(cursor_column) && $stable(cursor_row) && $stable(hw_cursor_position) && $stable(cell_value), "result changed while stalled")
  `TCW_ASSERT_IMPL(a_cursor_range, clk, rst, out_valid, cursor_column < tcw_pkg::MAX_COLS && cursor_row < tcw_pkg::MAX_ROWS, "cursor outside the largest screen")
  `TCW_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready, "item taken while the previous one executes")
  `TCW_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !out_valid, "result shown right after reset")

endmodule

bind text_console_writer tcw_checker u_checker (.*);
